/* rtl/core/tpli_pkg.sv */
// Shared types and constants for the piecewise-linear table interpolator.
// Holds the opcode and register index codes, the controller-to-datapath
// command and status structs, and the fixed arithmetic width. No dependencies.
`default_nettype none

package tpli_pkg;

  // Result arithmetic is unsigned 32-bit modular, whatever the table widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register index port width and reset values.
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CLAMP_LOW_RST  = 40;
  localparam int unsigned CLAMP_HIGH_RST = 305;

  // Input item opcode.
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } tpli_op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAMP_LOW    = 2'd0,
    CFG_CLAMP_HIGH   = 2'd1,
    CFG_ENTRIES_USED = 2'd2
  } tpli_cfg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_entry;  // write the input item into the table
    logic init;        // capture the clamped sample and open the search
    logic rd_mid;      // read the table at the search midpoint
    logic rd_lo;       // read the table at the low search bound
    logic rd_seg;      // read the lower breakpoint of the chosen segment
    logic rd_seg1;     // read the upper breakpoint of the chosen segment
    logic probe_step;  // narrow the search window after a miss
    logic take_mid;    // exact hit: the midpoint is the segment
    logic take_last;   // search closed: pick the segment from the low bound
    logic cap_lo;      // capture the lower breakpoint entry
    logic calc;        // form the temperature and ADC spans
    logic mul;         // form both dividends
    logic div_start;   // launch the divider
    logic add_b;       // form the intercept
    logic load_out;    // load the result register
  } tpli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_open;  // low bound still below high bound
    logic probe_hit;    // probed breakpoint equals the sample
    logic div_done;     // both quotients are ready
  } tpli_stat_t;

endpackage

`default_nettype wire

/* rtl/core/tpli_div.sv */
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on tpli_pkg for the data width and the step count.
`default_nettype none

module tpli_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tpli_pkg::DATA_W-1:0]  divisor_i,
  input  wire logic [tpli_pkg::DATA_W-1:0]  dividend0_i,
  input  wire logic [tpli_pkg::DATA_W-1:0]  dividend1_i,
  output logic      [tpli_pkg::DATA_W-1:0]  quot0_o,
  output logic      [tpli_pkg::DATA_W-1:0]  quot1_o,
  output logic                              done_o
);
  import tpli_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    dvs_q;
  logic [DATA_W-1:0]    rem0_q, rem1_q;
  logic [DATA_W-1:0]    dq0_q, dq1_q;
  logic [2*DATA_W-1:0]  step0, step1;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // The dividend register fills up with quotient bits from the right.
  function automatic logic [2*DATA_W-1:0] div_step(input logic [DATA_W-1:0] rem,
                                                   input logic [DATA_W-1:0] dq,
                                                   input logic [DATA_W-1:0] dvs);
    logic [DATA_W:0] t;
    logic [DATA_W:0] diff;
    logic            ge;
    t    = {rem, dq[DATA_W-1]};
    diff = t - {1'b0, dvs};
    ge   = (t >= {1'b0, dvs});
    return {(ge ? diff[DATA_W-1:0] : t[DATA_W-1:0]), dq[DATA_W-2:0], ge};
  endfunction

  assign step0 = div_step(rem0_q, dq0_q, dvs_q);
  assign step1 = div_step(rem1_q, dq1_q, dvs_q);

  // Step counter and completion flag.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Lane registers: partial remainder and dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q  <= divisor_i;
      rem0_q <= '0;
      rem1_q <= '0;
      dq0_q  <= dividend0_i;
      dq1_q  <= dividend1_i;
    end else if (busy_q) begin
      rem0_q <= step0[2*DATA_W-1:DATA_W];
      dq0_q  <= step0[DATA_W-1:0];
      rem1_q <= step1[2*DATA_W-1:DATA_W];
      dq1_q  <= step1[DATA_W-1:0];
    end
  end

  assign quot0_o = dq0_q;
  assign quot1_o = dq1_q;
  assign done_o  = done_q;

  // The divider is never both running and finished.
  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done at once");

  // Completion only follows the last step of a running division.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && $past(cnt_q) == DIV_CNT_W'(DIV_STEPS - 1))
    else $error("divider finished without running all steps");

endmodule

`default_nettype wire

/* rtl/core/tpli_ctrl.sv */
// Sequencing state machine for the table interpolator: input handshake,
// search steps, arithmetic phases and the output register's valid flag.
// Depends on tpli_pkg for the command and status structs and the opcode.
`default_nettype none

module tpli_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   op_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output tpli_pkg::tpli_cmd_t         cmd_o,
  input  wire tpli_pkg::tpli_stat_t   stat_i
);
  import tpli_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SRCH = 12'b0000_0000_0010,
    S_CMP  = 12'b0000_0000_0100,
    S_LAST = 12'b0000_0000_1000,
    S_RDLO = 12'b0000_0001_0000,
    S_RDHI = 12'b0000_0010_0000,
    S_CALC = 12'b0000_0100_0000,
    S_MUL  = 12'b0000_1000_0000,
    S_DIVS = 12'b0001_0000_0000,
    S_DIVW = 12'b0010_0000_0000,
    S_ADDB = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } tpli_state_e;

  tpli_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  // Items are taken only between conversions; loads finish on acceptance.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_entry = accept && (op_i == OP_LOAD);
        cmd_o.init       = accept && (op_i == OP_CONVERT);
        if (accept && (op_i == OP_CONVERT)) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat_i.search_open) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_CMP;
        end else begin
          cmd_o.rd_lo = 1'b1;
          state_d     = S_LAST;
        end
      end
      S_CMP: begin
        if (stat_i.probe_hit) begin
          cmd_o.take_mid = 1'b1;
          state_d        = S_RDLO;
        end else begin
          cmd_o.probe_step = 1'b1;
          state_d          = S_SRCH;
        end
      end
      S_LAST: begin
        cmd_o.take_last = 1'b1;
        state_d         = S_RDLO;
      end
      S_RDLO: begin
        cmd_o.rd_seg = 1'b1;
        state_d      = S_RDHI;
      end
      S_RDHI: begin
        cmd_o.rd_seg1 = 1'b1;
        cmd_o.cap_lo  = 1'b1;
        state_d       = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          state_d = S_ADDB;
        end
      end
      S_ADDB: begin
        cmd_o.add_b = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // A conversion blocks further input from the next cycle on.
  a_convert_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == OP_CONVERT) |=> in_stall_o)
    else $error("input not stalled during conversion");

  // A new result appears only at the end of a conversion.
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid without finishing a conversion");

endmodule

`default_nettype wire

/* rtl/core/tpli_dp.sv */
// Datapath of the table interpolator: configuration registers, breakpoint
// memory, binary-search bounds, span arithmetic and the result register.
// Depends on tpli_pkg and instantiates the divider tpli_div.
`default_nettype none

module tpli_dp #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TEMP_BITS   = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [tpli_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [((SAMPLE_BITS > $clog2(TABLE_DEPTH+1)) ? SAMPLE_BITS
                      : $clog2(TABLE_DEPTH+1))-1:0] cfg_wdata_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        entry_index_i,
  input  wire logic [SAMPLE_BITS-1:0]                adc_point_i,
  input  wire logic [TEMP_BITS-1:0]                  temp_point_i,
  input  wire logic [SAMPLE_BITS-1:0]                sample_i,
  input  wire tpli_pkg::tpli_cmd_t                   cmd_i,
  output tpli_pkg::tpli_stat_t                       stat_o,
  output logic [tpli_pkg::DATA_W-1:0]                temperature_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]             segment_o,
  output logic                                       zero_span_o
);
  import tpli_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CFG_W  = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
  localparam int unsigned WORD_W = SAMPLE_BITS + TEMP_BITS;
  localparam int unsigned SMAX   = (1 << SAMPLE_BITS) - 1;
  localparam logic [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'(CLAMP_LOW_RST);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST =
    (CLAMP_HIGH_RST > SMAX) ? SAMPLE_BITS'(SMAX) : SAMPLE_BITS'(CLAMP_HIGH_RST);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] clamp_low_q;
  logic [SAMPLE_BITS-1:0] clamp_high_q;
  logic [CNT_W-1:0]       entries_q;
  logic [CNT_W-1:0]       entries_wr;

  // Breakpoint memory.
  logic [WORD_W-1:0]      mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0]      rd_q;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] rd_adc;
  logic [TEMP_BITS-1:0]   rd_temp;

  // Search state.
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic [IDX_W-1:0]       lo_q, lo_d;
  logic signed [IDX_W:0]  hi_q, hi_d;
  logic [IDX_W-1:0]       mid_q;
  logic [IDX_W:0]         mid_sum;
  logic [IDX_W-1:0]       mid;
  logic [IDX_W-1:0]       seg_q, seg_d;
  logic signed [IDX_W:0]  cand;
  logic [IDX_W-1:0]       seg_max;

  // Arithmetic state.
  logic [SAMPLE_BITS-1:0] a0_q;
  logic [TEMP_BITS-1:0]   t0_q;
  logic [DATA_W-1:0]      d_q;
  logic [DATA_W-1:0]      w_q;
  logic                   zero_q;
  logic [DATA_W-1:0]      p0_q, p1_q;
  logic [DATA_W-1:0]      b_q;
  logic [DATA_W-1:0]      quot0, quot1;
  logic                   div_done;

  // Result register.
  logic [DATA_W-1:0]      temperature_q;
  logic [IDX_W-1:0]       segment_q;
  logic                   zero_span_q;

  // The entry count is saturated into its legal range when written.
  always_comb begin
    if (cfg_wdata_i < CFG_W'(2)) begin
      entries_wr = CNT_W'(2);
    end else if (cfg_wdata_i > CFG_W'(TABLE_DEPTH)) begin
      entries_wr = CNT_W'(TABLE_DEPTH);
    end else begin
      entries_wr = cfg_wdata_i[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= LOW_RST;
      clamp_high_q <= HIGH_RST;
      entries_q    <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLAMP_LOW:    clamp_low_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_CLAMP_HIGH:   clamp_high_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_ENTRIES_USED: entries_q    <= entries_wr;
        default: begin
        end
      endcase
    end
  end

  // Loads beyond the table are dropped.
  assign mem_we = cmd_i.load_entry &&
                  ({1'b0, entry_index_i} < (IDX_W + 1)'(TABLE_DEPTH));

  // Read address selection.
  always_comb begin
    if (cmd_i.rd_mid) begin
      rd_addr = mid;
    end else if (cmd_i.rd_seg) begin
      rd_addr = seg_q;
    end else if (cmd_i.rd_seg1) begin
      rd_addr = seg_q + IDX_W'(1);
    end else begin
      rd_addr = lo_q;
    end
  end

  // One write port for loads, one registered read port for the search and segment reads.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[entry_index_i] <= {adc_point_i, temp_point_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  assign rd_adc  = rd_q[TEMP_BITS +: SAMPLE_BITS];
  assign rd_temp = rd_q[TEMP_BITS-1:0];

  // Midpoint of the window; the high bound is positive while it is open.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q[IDX_W-1:0]};
  assign mid     = mid_sum[IDX_W:1];

  assign stat_o.search_open = $signed({1'b0, lo_q}) < hi_q;
  assign stat_o.probe_hit   = (rd_adc == x_q);
  assign stat_o.div_done    = div_done;

  // Sample clamp: the low bound is tested first, so it wins where both bounds apply.
  always_comb begin
    if (sample_i <= clamp_low_q) begin
      x_d = clamp_low_q;
    end else if (sample_i >= clamp_high_q) begin
      x_d = clamp_high_q;
    end else begin
      x_d = sample_i;
    end
  end

  // Search window update.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.init) begin
      lo_d = '0;
      hi_d = $signed((IDX_W + 1)'(entries_q - CNT_W'(1)));
    end else if (cmd_i.probe_step) begin
      if (x_q < rd_adc) begin
        hi_d = $signed({1'b0, mid_q}) - $signed((IDX_W + 1)'(1));
      end else begin
        lo_d = mid_q + IDX_W'(1);
      end
    end
  end

  // Segment choice, clamped to the first and the second-to-last entry.
  assign seg_max = IDX_W'(entries_q - CNT_W'(2));

  always_comb begin
    if (cmd_i.take_mid) begin
      cand = $signed({1'b0, mid_q});
    end else if (rd_adc < x_q) begin
      cand = $signed({1'b0, lo_q});
    end else begin
      cand = $signed({1'b0, lo_q}) - $signed((IDX_W + 1)'(1));
    end
    if (cand[IDX_W]) begin
      seg_d = '0;
    end else if (cand[IDX_W-1:0] > seg_max) begin
      seg_d = seg_max;
    end else begin
      seg_d = cand[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      x_q <= x_d;
    end
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.rd_mid) begin
      mid_q <= mid;
    end
    if (cmd_i.take_mid || cmd_i.take_last) begin
      seg_q <= seg_d;
    end
  end

  // Segment arithmetic: spans, products, intercept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lo) begin
      a0_q <= rd_adc;
      t0_q <= rd_temp;
    end
    if (cmd_i.calc) begin
      d_q    <= DATA_W'(t0_q) - DATA_W'(rd_temp);
      w_q    <= DATA_W'(rd_adc) - DATA_W'(a0_q);
      zero_q <= (rd_adc == a0_q);
    end
    if (cmd_i.mul) begin
      p0_q <= d_q * DATA_W'(a0_q);
      p1_q <= d_q * DATA_W'(x_q);
    end
    if (cmd_i.add_b) begin
      b_q <= DATA_W'(t0_q) - quot0;
    end
  end

  tpli_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .divisor_i   (w_q),
    .dividend0_i (p0_q),
    .dividend1_i (p1_q),
    .quot0_o     (quot0),
    .quot1_o     (quot1),
    .done_o      (div_done)
  );

  // Result register; a zero-width segment reports zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      temperature_q <= zero_q ? '0 : (quot1 + b_q);
      segment_q     <= seg_q;
      zero_span_q   <= zero_q;
    end
  end

  assign temperature_o = temperature_q;
  assign segment_o     = segment_q;
  assign zero_span_o   = zero_span_q;

  // A zero-width segment always yields a zero temperature.
  a_zero_span_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && zero_q) |=> (zero_span_o && temperature_o == '0))
    else $error("zero-width segment gave a nonzero temperature");

endmodule

`default_nettype wire

/* rtl/core/table_piecewise_linear_interp.sv */
// A load is written at its acceptance edge. A conversion runs a binary search of at most
// ceil(log2(entries_used)) search probes, ending early when a probe hits the sample
// exactly, then the segment reads, the span arithmetic, the two-lane divider and the
// intercept. Throughput: one conversion at a time, next item taken the cycle after the
// result registers; a stalled result holds it.
// Reset clears control state and loads the register defaults; the table is undefined.
// Top level of the piecewise-linear table interpolator.
// Connects tpli_ctrl and tpli_dp; depends on tpli_pkg.
`default_nettype none

module table_piecewise_linear_interp #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TEMP_BITS   = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [tpli_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [((SAMPLE_BITS > $clog2(TABLE_DEPTH+1)) ? SAMPLE_BITS
                      : $clog2(TABLE_DEPTH+1))-1:0] cfg_wdata_i,
  // Input channel.
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  op_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        entry_index_i,
  input  wire logic [SAMPLE_BITS-1:0]                adc_point_i,
  input  wire logic [TEMP_BITS-1:0]                  temp_point_i,
  input  wire logic [SAMPLE_BITS-1:0]                sample_i,
  // Output channel.
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [tpli_pkg::DATA_W-1:0]                temperature_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]             segment_o,
  output logic                                       zero_span_o
);
  import tpli_pkg::*;

  tpli_cmd_t  cmd;
  tpli_stat_t stat;

  tpli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tpli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TEMP_BITS   (TEMP_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .adc_point_i   (adc_point_i),
    .temp_point_i  (temp_point_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .temperature_o (temperature_o),
    .segment_o     (segment_o),
    .zero_span_o   (zero_span_o)
  );

endmodule

`default_nettype wire
